### sv/ccc_pkg.sv
// shared constants, angle table and gain helper for the coordinate converter
`default_nettype none

package ccc_pkg;

  localparam int unsigned IN_W   = 120;
  localparam int unsigned OUT_W  = 120;
  localparam int unsigned ATAN_N = 40;

  // degrees in q9.16
  localparam logic [24:0] DEG180 = 25'd11796480;
  localparam logic [24:0] DEG90  = 25'd5898240;

  typedef enum logic {
    ACT_TO_POLAR = 1'b0,
    ACT_TO_CART  = 1'b1
  } action_e;

  // atan(2^-i) in degrees, q.24
  localparam logic [29:0] ATAN_TAB [ATAN_N] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
    30'd30029717,  30'd15018523,  30'd7509720,   30'd3754917,   30'd1877466,
    30'd938734,    30'd469367,    30'd234684,    30'd117342,    30'd58671,
    30'd29335,     30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,       30'd57,
    30'd29,        30'd14,        30'd7,         30'd4,         30'd2,
    30'd1,         30'd0,         30'd0,         30'd0,         30'd0,
    30'd0,         30'd0,         30'd0,         30'd0,         30'd0
  };

  // square root of the cordic gain product (q.60), returned in q.30, evaluated at elaboration
  function automatic logic [63:0] gain_root(input int unsigned n);
    logic [63:0] g;
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    g = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < n) begin
        g = g + (g >> (2 * i));
      end
    end
    rem = g;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/complex_coordinate_converter.sv
// cartesian/polar converter: square root and shared cordic pipeline
// registers in order: stage 1, stage 2, the core stages, final stage 1 and the output
// stage; throughput one item per clock while the output is not stalled
// depth is set by the 32-step square root and the STAGES-step cordic,
// which run side by side in one pipeline
// reset clears the valid bits only; payload registers are not reset
`default_nettype none

module complex_coordinate_converter #(
  parameter int unsigned STAGES = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // real_part[31:0], imag_part[63:32], magnitude_in[94:64], phase_in[119:95]
  input  logic [ccc_pkg::IN_W-1:0]  s_axis_tdata,
  // action[0]
  input  logic [0:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // magnitude_out[30:0], phase_out[55:31], real_out[87:56], imag_out[119:88]
  output logic [ccc_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned CORE_N     = (STAGES > SQRT_STEPS) ? STAGES : SQRT_STEPS;
  localparam int unsigned XW         = 44;
  localparam int unsigned ZW         = 34;

  localparam logic [63:0] GAIN_ROOT = ccc_pkg::gain_root(STAGES);
  localparam logic [63:0] GAIN_FULL = ((64'd1 << 60) + (GAIN_ROOT >> 1)) / GAIN_ROOT;
  localparam logic [29:0] GAIN      = GAIN_FULL[29:0];

  localparam logic signed [ZW-1:0] Z90   = ZW'(64'd90 << 24);
  localparam logic signed [25:0]   PH90  = {1'b0, ccc_pkg::DEG90};
  localparam logic signed [25:0]   PH180 = {1'b0, ccc_pkg::DEG180};
  localparam logic signed [36:0]   S_MAX = 37'sd2147483647;
  localparam logic signed [36:0]   S_MIN = -37'sd2147483648;

  typedef struct packed {
    logic        act;
    logic        zero;
    logic        flip;
    logic [63:0] rem;
    logic [63:0] root;
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [ZW-1:0] z;
  } core_t;

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > S_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < S_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // input unpack
  logic               in_act;
  logic signed [31:0] in_re;
  logic signed [31:0] in_im;
  logic [30:0]        in_mag;
  logic signed [24:0] in_ph;

  assign in_act = s_axis_tuser[0];
  assign in_re  = s_axis_tdata[31:0];
  assign in_im  = s_axis_tdata[63:32];
  assign in_mag = s_axis_tdata[94:64];
  assign in_ph  = s_axis_tdata[119:95];

  // stage 1: magnitudes, half-plane turn, phase fold
  logic               s1_valid_q;
  logic               s1_act_q, s1_zero_q, s1_flip_q;
  logic [31:0]        s1_are_q, s1_aim_q;
  logic [30:0]        s1_mag_q;
  logic [XW-1:0]      s1_x_q, s1_y_q;
  logic [ZW-1:0]      s1_z_q;

  logic               s1_zero_d, s1_flip_d;
  logic [31:0]        s1_are_d, s1_aim_d;
  logic [XW-1:0]      s1_x_d, s1_y_d;
  logic [ZW-1:0]      s1_z_d;

  always_comb begin
    logic signed [XW-1:0] re_w;
    logic signed [XW-1:0] im_w;
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    logic signed [ZW-1:0] vz;
    logic signed [25:0]   ph_w;
    logic signed [25:0]   ph_f;
    s1_are_d  = in_re[31] ? 32'(-in_re) : 32'(in_re);
    s1_aim_d  = in_im[31] ? 32'(-in_im) : 32'(in_im);
    s1_zero_d = (in_re == 32'sd0) && (in_im == 32'sd0);
    re_w = {{(XW-40){in_re[31]}}, in_re, 8'd0};
    im_w = {{(XW-40){in_im[31]}}, in_im, 8'd0};
    if (in_re[31]) begin
      if (!in_im[31]) begin
        vx = im_w;
        vy = -re_w;
        vz = Z90;
      end else begin
        vx = -im_w;
        vy = re_w;
        vz = -Z90;
      end
    end else begin
      vx = re_w;
      vy = im_w;
      vz = '0;
    end
    ph_w      = {in_ph[24], in_ph};
    s1_flip_d = 1'b0;
    ph_f      = ph_w;
    if (ph_w > PH90) begin
      ph_f      = ph_w - PH180;
      s1_flip_d = 1'b1;
    end else if (ph_w < -PH90) begin
      ph_f      = ph_w + PH180;
      s1_flip_d = 1'b1;
    end
    if (in_act == ccc_pkg::ACT_TO_CART) begin
      s1_x_d = '0;
      s1_y_d = '0;
      s1_z_d = {ph_f, 8'd0};
    end else begin
      s1_x_d = vx;
      s1_y_d = vy;
      s1_z_d = vz;
    end
  end

  // stage 2: squares and gain multiply
  logic          s2_valid_q;
  logic          s2_act_q, s2_zero_q, s2_flip_q;
  logic [63:0]   s2_sqr_q, s2_sqi_q;
  logic [60:0]   s2_prod_q;
  logic [XW-1:0] s2_x_q, s2_y_q;
  logic [ZW-1:0] s2_z_q;

  // stage 3: sum of squares and cordic start
  core_t core_in;
  logic [61:0] prod_rnd;

  assign prod_rnd = {1'b0, s2_prod_q} + 62'(64'd1 << 21);

  always_comb begin
    core_in.act  = s2_act_q;
    core_in.zero = s2_zero_q;
    core_in.flip = s2_flip_q;
    core_in.rem  = s2_sqr_q + s2_sqi_q;
    core_in.root = '0;
    core_in.x    = (s2_act_q == ccc_pkg::ACT_TO_CART) ? {4'd0, prod_rnd[61:22]} : s2_x_q;
    core_in.y    = s2_y_q;
    core_in.z    = s2_z_q;
  end

  logic [CORE_N:0] core_valid_q;
  core_t           core_q [CORE_N+1];
  core_t           core_d [CORE_N];

  for (genvar k = 0; k < CORE_N; k++) begin : g_core
    logic [63:0]          rem_d;
    logic [63:0]          root_d;
    logic signed [XW-1:0] x_d;
    logic signed [XW-1:0] y_d;
    logic signed [ZW-1:0] z_d;

    if (k < SQRT_STEPS) begin : g_sqrt
      localparam logic [63:0] BT = 64'd1 << (62 - 2 * k);
      always_comb begin
        logic [63:0] trial;
        trial = core_q[k].root + BT;
        if (core_q[k].rem >= trial) begin
          rem_d  = core_q[k].rem - trial;
          root_d = (core_q[k].root >> 1) + BT;
        end else begin
          rem_d  = core_q[k].rem;
          root_d = core_q[k].root >> 1;
        end
      end
    end else begin : g_sqrt_idle
      assign rem_d  = core_q[k].rem;
      assign root_d = core_q[k].root;
    end

    if (k < STAGES) begin : g_rot
      localparam logic signed [ZW-1:0] ANG = ZW'(ccc_pkg::ATAN_TAB[k]);
      always_comb begin
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] zs;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic                 pos;
        xs  = $signed(core_q[k].x);
        ys  = $signed(core_q[k].y);
        zs  = $signed(core_q[k].z);
        dx  = ys >>> k;
        dy  = xs >>> k;
        pos = (core_q[k].act == ccc_pkg::ACT_TO_CART) ? !zs[ZW-1] : ys[XW-1];
        if (pos) begin
          x_d = xs - dx;
          y_d = ys + dy;
          z_d = zs - ANG;
        end else begin
          x_d = xs + dx;
          y_d = ys - dy;
          z_d = zs + ANG;
        end
      end
    end else begin : g_rot_idle
      assign x_d = $signed(core_q[k].x);
      assign y_d = $signed(core_q[k].y);
      assign z_d = $signed(core_q[k].z);
    end

    always_comb begin
      core_d[k]      = core_q[k];
      core_d[k].rem  = rem_d;
      core_d[k].root = root_d;
      core_d[k].x    = x_d;
      core_d[k].y    = y_d;
      core_d[k].z    = z_d;
    end
  end

  // final stage 1: rounding
  logic               f1_valid_q;
  logic               f1_act_q, f1_zero_q, f1_flip_q, f1_gt_q;
  logic [32:0]        f1_root_q;
  logic signed [25:0] f1_z_q;
  logic signed [35:0] f1_x_q, f1_y_q;

  core_t       c_last;
  logic [XW-1:0] x_rnd, y_rnd;
  logic [ZW-1:0] z_rnd;

  assign c_last = core_q[CORE_N];
  assign x_rnd  = c_last.x + XW'(128);
  assign y_rnd  = c_last.y + XW'(128);
  assign z_rnd  = c_last.z + ZW'(128);

  // output stage: saturation, clamp and mode select
  logic [ccc_pkg::OUT_W-1:0] m_data_d;
  logic [ccc_pkg::OUT_W-1:0] m_data_q;
  logic                      m_valid_q;

  always_comb begin
    logic [33:0]        r_inc;
    logic [30:0]        mag;
    logic signed [25:0] zc;
    logic [24:0]        ph;
    logic signed [36:0] xv;
    logic signed [36:0] yv;
    logic [31:0]        re_o;
    logic [31:0]        im_o;
    r_inc = {1'b0, f1_root_q} + 34'(f1_gt_q);
    mag   = (r_inc > 34'h7FFF_FFFF) ? 31'h7FFF_FFFF : r_inc[30:0];
    zc    = f1_z_q;
    if (zc > PH180) begin
      zc = PH180;
    end else if (zc < -PH180) begin
      zc = -PH180;
    end
    ph   = f1_zero_q ? 25'd0 : zc[24:0];
    xv   = {f1_x_q[35], f1_x_q};
    yv   = {f1_y_q[35], f1_y_q};
    if (f1_flip_q) begin
      xv = -xv;
      yv = -yv;
    end
    re_o = sat32(xv);
    im_o = sat32(yv);
    if (f1_act_q == ccc_pkg::ACT_TO_CART) begin
      m_data_d = {im_o, re_o, 25'd0, 31'd0};
    end else begin
      m_data_d = {32'd0, 32'd0, ph, mag};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      core_valid_q <= '0;
      f1_valid_q   <= 1'b0;
      m_valid_q    <= 1'b0;
    end else if (adv) begin
      s1_valid_q   <= s_axis_tvalid;
      s2_valid_q   <= s1_valid_q;
      core_valid_q <= {core_valid_q[CORE_N-1:0], s2_valid_q};
      f1_valid_q   <= core_valid_q[CORE_N];
      m_valid_q    <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_act_q  <= in_act;
      s1_zero_q <= s1_zero_d;
      s1_flip_q <= s1_flip_d;
      s1_are_q  <= s1_are_d;
      s1_aim_q  <= s1_aim_d;
      s1_mag_q  <= in_mag;
      s1_x_q    <= s1_x_d;
      s1_y_q    <= s1_y_d;
      s1_z_q    <= s1_z_d;

      s2_act_q  <= s1_act_q;
      s2_zero_q <= s1_zero_q;
      s2_flip_q <= s1_flip_q;
      s2_sqr_q  <= 64'(s1_are_q) * 64'(s1_are_q);
      s2_sqi_q  <= 64'(s1_aim_q) * 64'(s1_aim_q);
      s2_prod_q <= 61'(s1_mag_q) * 61'(GAIN);
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_z_q    <= s1_z_q;

      core_q[0] <= core_in;
      for (int k = 0; k < CORE_N; k++) begin
        core_q[k+1] <= core_d[k];
      end

      f1_act_q  <= c_last.act;
      f1_zero_q <= c_last.zero;
      f1_flip_q <= c_last.flip;
      f1_root_q <= c_last.root[32:0];
      f1_gt_q   <= c_last.rem > c_last.root;
      f1_z_q    <= z_rnd[ZW-1:8];
      f1_x_q    <= x_rnd[XW-1:8];
      f1_y_q    <= y_rnd[XW-1:8];

      m_data_q  <= m_data_d;
    end
  end

endmodule

`default_nettype wire

### sv/ccc_checker.sv
// port-level assertions for the coordinate converter, bound to the top level
`default_nettype none

module ccc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ccc_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam logic signed [25:0] PH_MAX = {1'b0, ccc_pkg::DEG180};

  logic signed [25:0] phase_w;
  assign phase_w = {m_axis_tdata[55], m_axis_tdata[55:31]};

  // stalled item stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // a full output register blocks new items
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (phase_w <= PH_MAX) && (phase_w >= -PH_MAX))
    else $error("phase outside -180..180");

  // cartesian results exclude polar results
  a_mode_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[119:56] != 64'd0) |-> m_axis_tdata[55:0] == 56'd0)
    else $error("polar and cartesian fields both set");

endmodule

bind complex_coordinate_converter ccc_checker u_ccc_checker (.*);

`default_nettype wire
